### rtl/waveform_charge_integrator_unit_assert.svh
// Assertion macros for the charge integrator RTL.
`ifndef WAVEFORM_CHARGE_INTEGRATOR_UNIT_ASSERT_SVH
`define WAVEFORM_CHARGE_INTEGRATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WCI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WCI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/wci_pkg.sv
// Shared constants, types and register codes of the charge integrator.
package wci_pkg;

    localparam int WAVEFORM_LENGTH = 1024;
    localparam int ADC_BITS        = 12;
    localparam int SAMPLE_W        = 12;
    localparam int CHANNEL_W       = 5;
    localparam int INDEX_W         = 11;
    localparam int PED_COUNT_W     = 11;
    localparam int SIG_START_W     = 10;
    localparam int SIG_END_W       = 11;
    localparam int PED_SUM_W       = 22;
    localparam int SIG_SUM_W       = 23;
    localparam int WIDTH_W         = 12;
    localparam int PED_Q8_W        = 20;
    localparam int CHARGE_W        = 32;
    localparam int FRAC_BITS       = 8;
    localparam int DIVIDEND_W      = PED_SUM_W + FRAC_BITS;
    localparam int DIV_CNT_W       = 5;
    localparam int CFG_INDEX_W     = 8;
    localparam int CFG_DATA_W      = 16;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_AW        = 1;
    localparam int QUEUE_CNT_W     = 2;

    localparam logic [PED_COUNT_W-1:0] PED_COUNT_RST = 11'd200;
    localparam logic [SIG_START_W-1:0] SIG_START_RST = 10'd200;
    localparam logic [SIG_END_W-1:0]   SIG_END_RST   = 11'd700;
    localparam logic [INDEX_W-1:0]     WAVE_LEN      = 11'd1024;
    localparam logic [SAMPLE_W:0]      FOLD_FULL     = 13'd4096;
    localparam logic [DIV_CNT_W-1:0]   DIV_LAST_STEP = 5'(DIVIDEND_W - 1);

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PED_COUNT = 8'd0,
        CFG_SIG_START = 8'd1,
        CFG_SIG_END   = 8'd2,
        CFG_FOLD_MODE = 8'd3
    } t_cfg_index;

    // One finished waveform, handed from the front to the back
    typedef struct packed {
        logic [CHANNEL_W-1:0]      channel;
        logic [PED_SUM_W-1:0]      ped_sum;
        logic [SIG_SUM_W-1:0]      sig_sum;
        logic [PED_COUNT_W-1:0]    ped_count;
        logic signed [WIDTH_W-1:0] width;
    } t_job;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_MUL,
        BK_OUT
    } t_back_state;

endpackage

### rtl/wci_front.sv
// Front end: configuration registers, sample accumulation, job issue.
module wci_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [wci_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [wci_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_valid,
    input  logic                             i_full,
    input  logic [wci_pkg::SAMPLE_W-1:0]     i_sample,
    input  logic [wci_pkg::CHANNEL_W-1:0]    i_channel,
    input  logic                             i_first_sample,
    input  logic                             i_beam,
    output logic                             o_push,
    output wci_pkg::t_job                    o_job
);
    import wci_pkg::*;

    logic [PED_COUNT_W-1:0] r_ped_count;
    logic [SIG_START_W-1:0] r_sig_start;
    logic [SIG_END_W-1:0]   r_sig_end;
    logic                   r_fold;

    logic [INDEX_W-1:0]   r_idx, n_idx;
    logic [PED_SUM_W-1:0] r_ped_sum, n_ped_sum;
    logic [SIG_SUM_W-1:0] r_sig_sum, n_sig_sum;
    logic [CHANNEL_W-1:0] r_chan, n_chan;
    logic                 r_active, n_active;

    logic                 w_accept;
    logic [INDEX_W-1:0]   w_idx;
    logic [PED_SUM_W-1:0] w_ped_base;
    logic [SIG_SUM_W-1:0] w_sig_base;
    logic                 w_act;
    logic                 w_in_len;
    logic                 w_in_win;
    logic                 w_ped_add;
    logic                 w_sig_add;
    logic                 w_emit;
    logic [SAMPLE_W:0]    w_folded;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ped_count <= PED_COUNT_RST;
            r_sig_start <= SIG_START_RST;
            r_sig_end   <= SIG_END_RST;
            r_fold      <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PED_COUNT: r_ped_count <= i_cfg_data[PED_COUNT_W-1:0];
                CFG_SIG_START: r_sig_start <= i_cfg_data[SIG_START_W-1:0];
                CFG_SIG_END:   r_sig_end   <= i_cfg_data[SIG_END_W-1:0];
                CFG_FOLD_MODE: r_fold      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Classify the incoming sample and advance the running sums
    always_comb begin
        w_accept   = i_valid && !i_full;
        w_idx      = i_first_sample ? '0 : r_idx;
        w_ped_base = i_first_sample ? '0 : r_ped_sum;
        w_sig_base = i_first_sample ? '0 : r_sig_sum;
        w_act      = i_first_sample ? i_beam : r_active;
        n_chan     = i_first_sample ? i_channel : r_chan;

        // fold low samples upward around half scale
        if (r_fold && !i_sample[ADC_BITS-1])
            w_folded = FOLD_FULL - {1'b0, i_sample};
        else
            w_folded = {1'b0, i_sample};

        w_in_len  = w_idx < WAVE_LEN;
        w_in_win  = w_idx < r_sig_end;
        w_ped_add = w_in_win && (w_idx < r_ped_count);
        w_sig_add = w_in_win && (w_idx >= {1'b0, r_sig_start});
        w_emit    = w_act && w_in_len && (r_sig_end != '0)
                    && (w_idx == r_sig_end - 11'd1);

        n_idx     = w_idx;
        n_ped_sum = w_ped_base;
        n_sig_sum = w_sig_base;
        n_active  = w_act;
        if (w_act) begin
            if (!w_in_len) begin
                n_active = 1'b0;
            end else begin
                if (w_ped_add)
                    n_ped_sum = w_ped_base + PED_SUM_W'(i_sample);
                if (w_sig_add)
                    n_sig_sum = w_sig_base + SIG_SUM_W'(w_folded);
                if (w_emit)
                    n_active = 1'b0;
                n_idx = w_idx + 11'd1;
            end
        end

        o_push          = w_accept && w_emit;
        o_job.channel   = n_chan;
        o_job.ped_sum   = n_ped_sum;
        o_job.sig_sum   = n_sig_sum;
        o_job.ped_count = r_ped_count;
        o_job.width     = $signed({1'b0, r_sig_end}) - $signed({2'b00, r_sig_start});
    end

    // Hold waveform state between transfers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_ped_sum <= '0;
            r_sig_sum <= '0;
            r_chan    <= '0;
            r_active  <= 1'b0;
        end else if (w_accept) begin
            r_idx     <= n_idx;
            r_ped_sum <= n_ped_sum;
            r_sig_sum <= n_sig_sum;
            r_chan    <= n_chan;
            r_active  <= n_active;
        end
    end

endmodule

### rtl/wci_queue.sv
// Two-entry job queue between the front end and the back end.
module wci_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  wci_pkg::t_job i_job,
    input  logic          i_pop,
    output wci_pkg::t_job o_job,
    output logic          o_full,
    output logic          o_empty
);
    import wci_pkg::*;
    `include "waveform_charge_integrator_unit_assert.svh"

    t_job                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]    r_wptr;
    logic [QUEUE_AW-1:0]    r_rptr;
    logic [QUEUE_CNT_W-1:0] r_count;

    assign o_full  = r_count == QUEUE_CNT_W'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_job   = r_mem[r_rptr];

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wptr] <= i_job;
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push)
                r_wptr <= r_wptr + 1'b1;
            if (i_pop)
                r_rptr <= r_rptr + 1'b1;
            if (i_push && !i_pop)
                r_count <= r_count + 1'b1;
            else if (i_pop && !i_push)
                r_count <= r_count - 1'b1;
        end
    end

    `WCI_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue count above depth")
    `WCI_ASSERT_NOW(a_push_room, i_clk, i_rst_n, i_push, !o_full, "push into full queue")
    `WCI_ASSERT_NOW(a_pop_data, i_clk, i_rst_n, i_pop, !o_empty, "pop from empty queue")
    `WCI_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1, "count did not rise on push")

endmodule

### rtl/wci_back.sv
// Back end: pedestal division, window multiply and charge subtraction.
module wci_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  wci_pkg::t_job                       i_job,
    input  logic                                i_empty,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [wci_pkg::CHANNEL_W-1:0]       o_out_channel,
    output logic [wci_pkg::PED_Q8_W-1:0]        o_pedestal_q8,
    output logic signed [wci_pkg::CHARGE_W-1:0] o_charge_q8
);
    import wci_pkg::*;

    t_back_state r_state, n_state;

    logic [DIV_CNT_W-1:0]       r_cnt, n_cnt;
    logic [DIVIDEND_W-1:0]      r_quo, n_quo;
    logic [PED_COUNT_W-1:0]     r_rem, n_rem;
    logic [PED_COUNT_W-1:0]     r_div, n_div;
    logic                       r_zero_div, n_zero_div;
    logic [SIG_SUM_W-1:0]       r_sig, n_sig;
    logic signed [WIDTH_W-1:0]  r_width, n_width;
    logic [CHANNEL_W-1:0]       r_chan, n_chan;
    logic [PED_Q8_W-1:0]        r_ped, n_ped;
    logic signed [32:0]         r_prod, n_prod;

    logic                       r_out_valid, n_out_valid;
    logic [CHANNEL_W-1:0]       r_out_chan, n_out_chan;
    logic [PED_Q8_W-1:0]        r_out_ped, n_out_ped;
    logic signed [CHARGE_W-1:0] r_out_charge, n_out_charge;

    logic [PED_COUNT_W:0]       w_rem_sh;
    logic [PED_COUNT_W:0]       w_rem_diff;
    logic                       w_ge;
    logic [PED_Q8_W-1:0]        w_ped;
    logic signed [PED_Q8_W:0]   w_ped_s;
    logic signed [33:0]         w_charge;

    // Sequence one job: divide, multiply, subtract, present
    always_comb begin
        w_rem_sh   = {r_rem, r_quo[DIVIDEND_W-1]};
        w_rem_diff = w_rem_sh - {1'b0, r_div};
        w_ge       = w_rem_sh >= {1'b0, r_div};
        w_ped      = r_zero_div ? '0 : r_quo[PED_Q8_W-1:0];
        w_ped_s    = $signed({1'b0, w_ped});
        w_charge   = $signed({3'b000, r_sig, {FRAC_BITS{1'b0}}}) - $signed({r_prod[32], r_prod});

        n_state      = r_state;
        n_cnt        = r_cnt;
        n_quo        = r_quo;
        n_rem        = r_rem;
        n_div        = r_div;
        n_zero_div   = r_zero_div;
        n_sig        = r_sig;
        n_width      = r_width;
        n_chan       = r_chan;
        n_ped        = r_ped;
        n_prod       = r_prod;
        n_out_chan   = r_out_chan;
        n_out_ped    = r_out_ped;
        n_out_charge = r_out_charge;
        n_out_valid  = r_out_valid && i_stall;
        o_pop        = 1'b0;

        unique case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    o_pop      = 1'b1;
                    n_quo      = {i_job.ped_sum, {FRAC_BITS{1'b0}}};
                    n_rem      = '0;
                    n_div      = i_job.ped_count;
                    n_zero_div = i_job.ped_count == '0;
                    n_sig      = i_job.sig_sum;
                    n_width    = i_job.width;
                    n_chan     = i_job.channel;
                    n_cnt      = DIV_LAST_STEP;
                    n_state    = BK_DIV;
                end
            end
            BK_DIV: begin
                // one restoring quotient bit per cycle
                n_rem = w_ge ? w_rem_diff[PED_COUNT_W-1:0] : w_rem_sh[PED_COUNT_W-1:0];
                n_quo = {r_quo[DIVIDEND_W-2:0], w_ge};
                if (r_cnt == '0)
                    n_state = BK_MUL;
                else
                    n_cnt = r_cnt - 1'b1;
            end
            BK_MUL: begin
                n_ped   = w_ped;
                n_prod  = r_width * w_ped_s;
                n_state = BK_OUT;
            end
            BK_OUT: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_chan   = r_chan;
                    n_out_ped    = r_ped;
                    n_out_charge = w_charge[CHARGE_W-1:0];
                    n_state      = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // Hold the state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold datapath and output registers
    always_ff @(posedge i_clk) begin
        r_cnt        <= n_cnt;
        r_quo        <= n_quo;
        r_rem        <= n_rem;
        r_div        <= n_div;
        r_zero_div   <= n_zero_div;
        r_sig        <= n_sig;
        r_width      <= n_width;
        r_chan       <= n_chan;
        r_ped        <= n_ped;
        r_prod       <= n_prod;
        r_out_chan   <= n_out_chan;
        r_out_ped    <= n_out_ped;
        r_out_charge <= n_out_charge;
    end

    assign o_valid       = r_out_valid;
    assign o_out_channel = r_out_chan;
    assign o_pedestal_q8 = r_out_ped;
    assign o_charge_q8   = r_out_charge;

endmodule

### rtl/waveform_charge_integrator_unit.sv
// Top level of the pedestal-subtracted waveform charge integrator.
//
// Input channel (i_valid / o_stall): one ADC sample per transfer, with its
// channel, a first-sample mark and a beam flag. Samples are taken at one per
// cycle; o_stall rises only while the two-entry job queue is full.
// Configuration (i_cfg_valid / o_cfg_ready): index 0 pedestal count, 1 signal
// start, 2 signal end, 3 fold mode; o_cfg_ready is always high and unknown
// indexes are dropped. Write it only while the block is idle.
// Output channel (o_valid / i_stall): one result per beam waveform reaching
// index signal_end-1: channel, Q8 pedestal and signed Q8 charge.
// A waveform's result reaches the output once the back end has popped its
// job and passed it through the 30-step restoring pedestal divider, a
// multiply and a subtract; the output is registered. Meanwhile the front
// end keeps taking samples, with two waveforms of queue slack.
// Reset clears the waveform state, the queue and the output valid, and
// loads the register defaults (200, 200, 700, fold off). A stalled output
// holds its result; the back end waits on it and the queue absorbs jobs.
module waveform_charge_integrator_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [wci_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [wci_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [wci_pkg::SAMPLE_W-1:0]        i_sample,
    input  logic [wci_pkg::CHANNEL_W-1:0]       i_channel,
    input  logic                                i_first_sample,
    input  logic                                i_beam,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [wci_pkg::CHANNEL_W-1:0]       o_out_channel,
    output logic [wci_pkg::PED_Q8_W-1:0]        o_pedestal_q8,
    output logic signed [wci_pkg::CHARGE_W-1:0] o_charge_q8
);
    import wci_pkg::*;

    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;
    t_job w_push_job;
    t_job w_pop_job;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = w_full;

    // Accumulate samples and issue finished waveforms
    wci_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .i_full         (w_full),
        .i_sample       (i_sample),
        .i_channel      (i_channel),
        .i_first_sample (i_first_sample),
        .i_beam         (i_beam),
        .o_push         (w_push),
        .o_job          (w_push_job)
    );

    // Decouple front and back
    wci_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_pop_job),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // Compute pedestal and charge
    wci_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (w_pop_job),
        .i_empty       (w_empty),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_channel (o_out_channel),
        .o_pedestal_q8 (o_pedestal_q8),
        .o_charge_q8   (o_charge_q8)
    );

endmodule
